[rtl/bilinear_pixel_sampler_top_assert.svh]
// Assertion macros shared by the bilinear pixel sampler checkers.
`ifndef BILINEAR_PIXEL_SAMPLER_TOP_ASSERT_SVH
`define BILINEAR_PIXEL_SAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BPS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> cons) \
    else $error(msg);

`endif

[rtl/bps_pkg.sv]
// Package: constants, types and register codes of the bilinear pixel sampler.
package bps_pkg;

  // Image store geometry and fixed-point format
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int FRAC_BITS  = 8;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PIX_W   = 8;
  localparam int QUERY_W = 17;
  localparam int CFG_W   = 10;
  localparam int INT_W   = QUERY_W - FRAC_BITS;

  // Four parity banks: row parity x column parity
  localparam int BANK_AW    = (ROW_W - 1) + (COL_W - 1);
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  // Weight and accumulator widths
  localparam int FRAC1_W = FRAC_BITS + 1;
  localparam int WGT_W   = 2 * FRAC_BITS + 1;
  localparam int PROD_W  = 2 * FRAC_BITS + PIX_W;
  localparam int SUM_W   = PROD_W + 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  // Request function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] a;
    logic [PIX_W-1:0] b;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] d;
  } pix_quad_t;

  // Pipeline advance controls from the top level
  typedef struct packed {
    logic ld1;
    logic en2;
    logic en3;
    logic en4;
  } adv_t;

endpackage

[rtl/bps_if.sv]
// Request and response channel interfaces of the bilinear pixel sampler.
interface bps_req_if import bps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [ROW_W-1:0]   pixel_row;
  logic [COL_W-1:0]   pixel_col;
  logic [PIX_W-1:0]   pixel_value;
  logic [QUERY_W-1:0] query_x;
  logic [QUERY_W-1:0] query_y;

  modport source (
    output valid, func, pixel_row, pixel_col, pixel_value, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, func, pixel_row, pixel_col, pixel_value, query_x, query_y,
    output ready
  );
endinterface

interface bps_rsp_if import bps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] sample_value;

  modport source (
    output valid, sample_value,
    input  ready
  );
  modport sink (
    input  valid, sample_value,
    output ready
  );
endinterface

[rtl/bps_bank.sv]
// One pixel bank: synchronous RAM, one write and one registered read port.
module bps_bank import bps_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [BANK_AW-1:0] waddr_i,
  input  logic [PIX_W-1:0]   wdata_i,
  input  logic               re_i,
  input  logic [BANK_AW-1:0] raddr_i,
  output logic [PIX_W-1:0]   rdata_o
);

  logic [PIX_W-1:0] mem [BANK_DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bps_store.sv]
// Pixel store: four parity banks, edge clamping and neighbour fetch.
module bps_store import bps_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic               re_i,
  input  logic [ROW_W-1:0]   pixel_row_i,
  input  logic [COL_W-1:0]   pixel_col_i,
  input  logic [PIX_W-1:0]   pixel_value_i,
  input  logic [QUERY_W-1:0] query_x_i,
  input  logic [QUERY_W-1:0] query_y_i,
  input  logic [CFG_W-1:0]   width_i,
  input  logic [CFG_W-1:0]   height_i,
  output pix_quad_t          pix_o
);

  // Last usable index for an edge register: zero acts as one, above max as max
  function automatic logic [INT_W-1:0] edge_last(logic [CFG_W-1:0] lim,
                                                 logic [CFG_W-1:0] lim_max);
    logic [CFG_W-1:0] m1;
    m1 = lim - CFG_W'(1);
    if (lim == '0) begin
      return '0;
    end else if (lim > lim_max) begin
      m1 = lim_max - CFG_W'(1);
      return m1[INT_W-1:0];
    end
    return m1[INT_W-1:0];
  endfunction

  // Clamp an index (one bit of headroom) to the last usable index
  function automatic logic [INT_W-1:0] clamp_idx(logic [INT_W:0] idx,
                                                 logic [INT_W-1:0] last);
    if (idx > {1'b0, last}) begin
      return last;
    end
    return idx[INT_W-1:0];
  endfunction

  localparam logic [CFG_W-1:0] WIDTH_MAX  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_MAX = CFG_W'(MAX_HEIGHT);

  logic [INT_W-1:0] xi, yi, col_last, row_last;
  logic [INT_W-1:0] c0, c1, r0, r1;
  logic [COL_W-1:0] col_sel [2];
  logic [ROW_W-1:0] row_sel [2];
  logic [PIX_W-1:0] rdata [4];
  logic             r0p_q, r1p_q, c0p_q, c1p_q;

  // Integer parts and clamped neighbour indexes
  always_comb begin
    xi       = query_x_i[QUERY_W-1:FRAC_BITS];
    yi       = query_y_i[QUERY_W-1:FRAC_BITS];
    col_last = edge_last(width_i, WIDTH_MAX);
    row_last = edge_last(height_i, HEIGHT_MAX);
    c0       = clamp_idx({1'b0, xi}, col_last);
    c1       = clamp_idx({1'b0, xi} + (INT_W+1)'(1), col_last);
    r0       = clamp_idx({1'b0, yi}, row_last);
    r1       = clamp_idx({1'b0, yi} + (INT_W+1)'(1), row_last);
  end

  // Each parity bank takes whichever neighbour index has its parity
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      col_sel[p] = (c0[0] == p[0]) ? c0[COL_W-1:0] : c1[COL_W-1:0];
      row_sel[p] = (r0[0] == p[0]) ? r0[ROW_W-1:0] : r1[ROW_W-1:0];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    localparam logic RP = g[1];
    localparam logic CP = g[0];
    logic bank_we;
    assign bank_we = we_i && (pixel_row_i[0] == RP) && (pixel_col_i[0] == CP);

    bps_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i ({pixel_row_i[ROW_W-1:1], pixel_col_i[COL_W-1:1]}),
      .wdata_i (pixel_value_i),
      .re_i    (re_i),
      .raddr_i ({row_sel[RP][ROW_W-1:1], col_sel[CP][COL_W-1:1]}),
      .rdata_o (rdata[g])
    );
  end

  // Parities travel with the read so the bank outputs can be routed
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      r0p_q <= r0[0];
      r1p_q <= r1[0];
      c0p_q <= c0[0];
      c1p_q <= c1[0];
    end
  end

  always_comb begin
    pix_o.a = rdata[{r0p_q, c0p_q}];
    pix_o.b = rdata[{r0p_q, c1p_q}];
    pix_o.c = rdata[{r1p_q, c0p_q}];
    pix_o.d = rdata[{r1p_q, c1p_q}];
  end

endmodule

[rtl/bps_blend.sv]
// Blend pipeline: weights, weighted products, rounded sum.
module bps_blend import bps_pkg::*; (
  input  logic               clk_i,
  input  adv_t               adv_i,
  input  logic [QUERY_W-1:0] query_x_i,
  input  logic [QUERY_W-1:0] query_y_i,
  input  pix_quad_t          pix_i,
  output logic [PIX_W-1:0]   sample_value_o
);

  localparam logic [FRAC1_W-1:0] ONE  = FRAC1_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0]   HALF = SUM_W'(1) << (2 * FRAC_BITS - 1);

  logic [FRAC_BITS-1:0]   fx_q, fy_q;
  logic [FRAC1_W-1:0]     fx, fy, gx, gy;
  logic [2*FRAC1_W-1:0]   wa, wb, wc, wd;
  logic [WGT_W-1:0]       wa_q, wb_q, wc_q, wd_q;
  pix_quad_t              pix2_q;
  logic [WGT_W+PIX_W-1:0] pa, pb, pc, pd;
  logic [PROD_W-1:0]      pa_q, pb_q, pc_q, pd_q;
  logic [SUM_W-1:0]       sum;
  logic [PIX_W-1:0]       sample_value_q;

  // Stage 1: fractions, loaded with the bank read
  always_ff @(posedge clk_i) begin
    if (adv_i.ld1) begin
      fx_q <= query_x_i[FRAC_BITS-1:0];
      fy_q <= query_y_i[FRAC_BITS-1:0];
    end
  end

  // Stage 2: four corner weights, always summing to one
  always_comb begin
    fx = {1'b0, fx_q};
    fy = {1'b0, fy_q};
    gx = ONE - fx;
    gy = ONE - fy;
    wa = gx * gy;
    wb = fx * gy;
    wc = gx * fy;
    wd = fx * fy;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en2) begin
      wa_q   <= wa[WGT_W-1:0];
      wb_q   <= wb[WGT_W-1:0];
      wc_q   <= wc[WGT_W-1:0];
      wd_q   <= wd[WGT_W-1:0];
      pix2_q <= pix_i;
    end
  end

  // Stage 3: weighted pixels
  always_comb begin
    pa = wa_q * pix2_q.a;
    pb = wb_q * pix2_q.b;
    pc = wc_q * pix2_q.c;
    pd = wd_q * pix2_q.d;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en3) begin
      pa_q <= pa[PROD_W-1:0];
      pb_q <= pb[PROD_W-1:0];
      pc_q <= pc[PROD_W-1:0];
      pd_q <= pd[PROD_W-1:0];
    end
  end

  // Stage 4: sum, round half up, drop the fraction
  assign sum = SUM_W'(pa_q) + SUM_W'(pb_q) + SUM_W'(pc_q) + SUM_W'(pd_q) + HALF;

  always_ff @(posedge clk_i) begin
    if (adv_i.en4) begin
      sample_value_q <= sum[2*FRAC_BITS +: PIX_W];
    end
  end

  assign sample_value_o = sample_value_q;

endmodule

[rtl/bilinear_pixel_sampler_top.sv]
// Bilinear pixel sampler top level: handshake, config registers, pipeline control.
//
// Usage:
//   req_i carries one request per handshake. func = write stores pixel_value at
//   (pixel_row, pixel_col); func = sample returns one blended value on rsp_o
//   for the position (query_x, query_y), 8 fraction bits, clamped to the edges
//   set by image_width (index 0) and image_height (index 1) on the cfg port.
//   Write requests produce no response.
// Throughput: one request per cycle while req_i.ready is high. The four
//   neighbours come from four row/column parity banks, one read per bank,
//   so a sample is fetched in one read; a write uses one bank.
// Pipeline: rsp_o.valid rises once an accepted sample has passed the bank
//   read, weights, products and rounded sum registers, in that order; the
//   response handshake is delayed further only under stall.
// Reset: pipeline empties, both edge registers return to 512. The pixel banks
//   are not cleared; pixels must be written before they are sampled.
// Stall: when rsp_o is held, the response register keeps its value and the
//   stages behind it fill up; req_i.ready drops only once all stages are full.
module bilinear_pixel_sampler_top import bps_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  bps_req_if.sink              req_i,
  bps_rsp_if.source            rsp_o
);

  logic [CFG_W-1:0] width_q, height_q;
  logic             v1_q, v2_q, v3_q, v4_q;
  logic             en1, en2, en3, en4;
  logic             req_acc;
  adv_t             adv;
  pix_quad_t        pix;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(MAX_WIDTH);
      height_q <= CFG_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_data_i;
        CFG_IDX_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each stage moves when the one after it is empty or moving
  assign en4     = !v4_q || rsp_o.ready;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign req_acc = req_i.valid && en1;

  assign adv.ld1 = req_acc && (req_i.func == FUNC_SAMPLE);
  assign adv.en2 = en2;
  assign adv.en3 = en3;
  assign adv.en4 = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= adv.ld1;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  bps_store u_store (
    .clk_i         (clk_i),
    .we_i          (req_acc && (req_i.func == FUNC_WRITE)),
    .re_i          (adv.ld1),
    .pixel_row_i   (req_i.pixel_row),
    .pixel_col_i   (req_i.pixel_col),
    .pixel_value_i (req_i.pixel_value),
    .query_x_i     (req_i.query_x),
    .query_y_i     (req_i.query_y),
    .width_i       (width_q),
    .height_i      (height_q),
    .pix_o         (pix)
  );

  bps_blend u_blend (
    .clk_i          (clk_i),
    .adv_i          (adv),
    .query_x_i      (req_i.query_x),
    .query_y_i      (req_i.query_y),
    .pix_i          (pix),
    .sample_value_o (rsp_o.sample_value)
  );

  assign req_i.ready = en1;
  assign rsp_o.valid = v4_q;

endmodule

[rtl/bps_checker.sv]
// Port-level checker for the bilinear pixel sampler, bound to the top level.
`include "bilinear_pixel_sampler_top_assert.svh"

module bps_checker import bps_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             req_func_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [PIX_W-1:0] sample_value_i
);

  // A held response keeps its value
  `BPS_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(sample_value_i), "response dropped or changed while stalled")

  // Requests are only refused when the response side is stalled
  `BPS_ASSERT_IMP(a_stall_src, clk_i, rst_ni, !req_ready_i, rsp_valid_i && !rsp_ready_i, "request refused without output stall")

  // An accepted sample request is followed by a valid response after the pipeline
  `BPS_ASSERT_IMP(a_sample_lat, clk_i, rst_ni, req_valid_i && req_ready_i && (req_func_i == FUNC_SAMPLE), ##4 rsp_valid_i, "sample request produced no response in time")

endmodule

bind bilinear_pixel_sampler_top bps_checker u_bps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_func_i     (req_i.func),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .sample_value_i (rsp_o.sample_value)
);
